// File: rtl/weighted_set_expander_top_macros.svh
// Assertion helpers used by wse_ctrl.
`ifndef WEIGHTED_SET_EXPANDER_TOP_MACROS_SVH
`define WEIGHTED_SET_EXPANDER_TOP_MACROS_SVH

// Property checked at every clock edge outside reset.
`define WSE_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent checked in the cycle after the antecedent holds.
`define WSE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/wse_pkg.sv
package wse_pkg;

  localparam int FID_W      = 20;
  localparam int WHOLE_W    = 6;
  localparam int FRAC_W     = 32;
  localparam int ID_W       = 41;
  localparam int SCALE_W    = 17;
  localparam int SEED_W     = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 17;
  localparam int PROD_W     = FID_W + 1 + SCALE_W;
  localparam int STEP_W     = 8;

  localparam int MAX_COPIES_DEF = 63;

  localparam logic [SCALE_W-1:0] SCALE_RST = 17'd1000;
  localparam logic [SEED_W-1:0]  SEED_RST  = 6'd1;

  localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED  = 1'b1;

  // Generator constants.
  localparam int          MT_MID      = 156;
  localparam logic [63:0] MT_MATRIX   = 64'hB5026F5AA96619E9;
  localparam logic [63:0] MT_UPPER    = 64'hFFFFFFFF80000000;
  localparam logic [63:0] MT_LOWER    = 64'h000000007FFFFFFF;
  localparam logic [63:0] MT_INIT_MUL = 64'd6364136223846793005;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_DRAW,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic mul_en;
    logic add_en;
    logic draw_en;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic step_last;
    logic slot_free;
    logic emit_last;
  } sts_t;

  // Twist of word 0 followed by tempering; cur is state word MT_MID.
  function automatic logic [63:0] mt_temper(input logic [63:0] x0,
                                            input logic [63:0] x1,
                                            input logic [63:0] cur);
    logic [63:0] y;
    y = (x0 & MT_UPPER) | (x1 & MT_LOWER);
    y = cur ^ (y >> 1) ^ (y[0] ? MT_MATRIX : 64'd0);
    y = y ^ ((y >> 29) & 64'h5555555555555555);
    y = y ^ ((y << 17) & 64'h71D67FFFEDA60000);
    y = y ^ ((y << 37) & 64'hFFF7EEE000000000);
    y = y ^ (y >> 43);
    return y;
  endfunction

endpackage

// File: rtl/wse_ctrl.sv
`include "weighted_set_expander_top_macros.svh"

module wse_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  wse_pkg::sts_t sts_i,
  output wse_pkg::cmd_t cmd_o
);
  import wse_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_MUL;
      end
      ST_MUL:  state_d = ST_ADD;
      ST_ADD: begin
        if (sts_i.step_last) state_d = ST_DRAW;
        else state_d = ST_MUL;
      end
      ST_DRAW: state_d = ST_EMIT;
      ST_EMIT: begin
        if (sts_i.slot_free && sts_i.emit_last) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_MUL:  cmd_o.mul_en  = 1'b1;
      ST_ADD:  cmd_o.add_en  = 1'b1;
      ST_DRAW: cmd_o.draw_en = 1'b1;
      ST_EMIT: cmd_o.emit    = sts_i.slot_free;
      default: cmd_o = '0;
    endcase
  end

  `WSE_ASSERT(a_emit_needs_slot, clk_i, rst_ni, !cmd_o.emit || sts_i.slot_free, "emit into a full output register")
  `WSE_ASSERT_NEXT(a_load_starts_gen, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_MUL, "accepted beat did not start the generator")
  `WSE_ASSERT_NEXT(a_last_emit_idle, clk_i, rst_ni, cmd_o.emit && sts_i.emit_last, state_q == ST_IDLE, "final result did not return to idle")

endmodule

// File: rtl/wse_dp.sv
module wse_dp #(
  parameter int MaxCopies = wse_pkg::MAX_COPIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wse_pkg::cmd_t                  cmd_i,
  output wse_pkg::sts_t                  sts_o,
  input  logic [wse_pkg::FID_W-1:0]      feature_id_i,
  input  logic [wse_pkg::WHOLE_W-1:0]    weight_whole_i,
  input  logic [wse_pkg::FRAC_W-1:0]     weight_frac_i,
  input  logic                           last_feature_i,
  input  logic [wse_pkg::SCALE_W-1:0]    scale_i,
  input  logic [wse_pkg::SEED_W-1:0]     seed_i,
  input  logic                           out_ready_i,
  output logic                           out_valid_o,
  output logic [wse_pkg::ID_W-1:0]       expanded_id_o,
  output logic                           copy_valid_o,
  output logic                           last_of_run_o,
  output logic                           set_done_o
);
  import wse_pkg::*;

  localparam int KW = $clog2(MaxCopies + 2);

  // Captured feature.
  logic [FID_W-1:0]  fid_q;
  logic [KW-1:0]     whole_q;
  logic [FRAC_W-1:0] frac_q;
  logic              last_q;

  // Generator state.
  logic [63:0]       x0_q, x1_q, prev_q, prev_d, mix, gseed, draw;
  logic [63:0]       pll_q;
  logic [31:0]       plh_q, phl_q;
  logic [STEP_W-1:0] step_q;
  logic              pass;

  // Emission.
  logic [PROD_W-1:0] prod_q;
  logic [ID_W-1:0]   base_q;
  logic [KW-1:0]     nres_q, k_q, whole_cap;
  logic              marker, emit_last;
  logic              out_valid_q, copy_q, lor_q, done_q;
  logic [ID_W-1:0]   id_q;

  assign gseed = (seed_i == '0) ? 64'(feature_id_i >> 1)
                                : (64'(feature_id_i) << (seed_i - SEED_W'(1)));
  assign whole_cap = (32'(weight_whole_i) > 32'(MaxCopies)) ? KW'(MaxCopies)
                                                             : KW'(weight_whole_i);

  assign mix    = prev_q ^ (prev_q >> 62);
  // Low 64 bits of the product from three 32-bit partial products, plus the step index.
  assign prev_d = pll_q + {plh_q + phl_q, 32'd0} + 64'(step_q);

  assign draw = mt_temper(x0_q, x1_q, prev_q);
  assign pass = draw[63:32] < frac_q;

  assign marker    = (nres_q == '0);
  assign emit_last = marker || ((k_q + KW'(1)) == nres_q);

  assign sts_o.step_last = (step_q == STEP_W'(MT_MID));
  assign sts_o.slot_free = !out_valid_q || out_ready_i;
  assign sts_o.emit_last = emit_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      step_q      <= '0;
      k_q         <= '0;
    end else begin
      if (cmd_i.load) step_q <= STEP_W'(1);
      else if (cmd_i.add_en) step_q <= step_q + STEP_W'(1);
      if (cmd_i.draw_en) k_q <= '0;
      else if (cmd_i.emit) k_q <= k_q + KW'(1);
      if (cmd_i.emit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      fid_q   <= feature_id_i;
      whole_q <= whole_cap;
      frac_q  <= weight_frac_i;
      last_q  <= last_feature_i;
      x0_q    <= gseed;
      prev_q  <= gseed;
    end
    if (cmd_i.mul_en) begin
      pll_q  <= 64'(mix[31:0]) * 64'(MT_INIT_MUL[31:0]);
      plh_q  <= mix[31:0] * MT_INIT_MUL[63:32];
      phl_q  <= mix[63:32] * MT_INIT_MUL[31:0];
      prod_q <= PROD_W'(PROD_W'(fid_q) + PROD_W'(1)) * PROD_W'(scale_i);
    end
    if (cmd_i.add_en) begin
      prev_q <= prev_d;
      if (step_q == STEP_W'(1)) x1_q <= prev_d;
    end
    if (cmd_i.draw_en) begin
      base_q <= ID_W'({prod_q, 3'b000}) + ID_W'({prod_q, 1'b0});
      nres_q <= whole_q + KW'(pass);
    end
    if (cmd_i.emit) begin
      id_q   <= marker ? '0 : base_q + ID_W'(k_q);
      copy_q <= !marker;
      lor_q  <= emit_last;
      done_q <= emit_last && last_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign expanded_id_o = id_q;
  assign copy_valid_o  = copy_q;
  assign last_of_run_o = lor_q;
  assign set_done_o    = done_q;

endmodule

// File: rtl/weighted_set_expander_top.sv
// An item runs the generator's seeding steps (a multiply state and an add state per seeding
// step), one draw state and then one result per cycle while the output register is free:
// the block takes the next item after its last result is written, with n results per item
// (n from 1 to MaxCopies + 1, that is 1 to 64 by default).
// Reset (rst_ni low, asynchronous) empties the output register, idles the controller
// and sets scale to 1000 and seed to 1.
module weighted_set_expander_top #(
  parameter int MaxCopies = wse_pkg::MAX_COPIES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [wse_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [wse_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [wse_pkg::FID_W-1:0]      feature_id_i,
  input  logic [wse_pkg::WHOLE_W-1:0]    weight_whole_i,
  input  logic [wse_pkg::FRAC_W-1:0]     weight_frac_i,
  input  logic                           last_feature_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [wse_pkg::ID_W-1:0]       expanded_id_o,
  output logic                           copy_valid_o,
  output logic                           last_of_run_o,
  output logic                           set_done_o
);
  import wse_pkg::*;

  logic [SCALE_W-1:0] scale_q;
  logic [SEED_W-1:0]  seed_q;
  cmd_t               cmd;
  sts_t               sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q <= SCALE_RST;
      seed_q  <= SEED_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_SCALE: scale_q <= cfg_wdata_i[SCALE_W-1:0];
        CFG_SEED:  seed_q  <= cfg_wdata_i[SEED_W-1:0];
        default:   ;
      endcase
    end
  end

  wse_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  wse_dp #(
    .MaxCopies (MaxCopies)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .feature_id_i   (feature_id_i),
    .weight_whole_i (weight_whole_i),
    .weight_frac_i  (weight_frac_i),
    .last_feature_i (last_feature_i),
    .scale_i        (scale_q),
    .seed_i         (seed_q),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .expanded_id_o  (expanded_id_o),
    .copy_valid_o   (copy_valid_o),
    .last_of_run_o  (last_of_run_o),
    .set_done_o     (set_done_o)
  );

endmodule
